FILE: rtl/ldmc_pkg.sv
package ldmc_pkg;

    localparam int unsigned AW          = 11;
    localparam int unsigned PLANE_DEPTH = 2048;

    typedef enum logic [2:0] {
        OP_BUF_RD = 3'd0,
        OP_BUF_WR = 3'd1,
        OP_REG_RD = 3'd2,
        OP_REG_WR = 3'd3,
        OP_FRAME  = 3'd4,
        OP_SCAN   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        REG_RANGE    = 2'd0,
        REG_MODE     = 2'd1,
        REG_CONTRAST = 2'd2,
        REG_SELECT   = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_PREP,
        S_RD,
        S_EXEC,
        S_SCAN
    } t_state;

    localparam logic [2:0] MODE_CLEAR = 3'd4;
    localparam logic [2:0] MODE_SHOW  = 3'd5;
    localparam logic [2:0] MODE_TEST  = 3'd6;

    localparam logic [1:0] PM_SINGLE = 2'd0;
    localparam logic [1:0] PM_SPLIT  = 2'd1;

    localparam logic CFG_PLANE_MODE = 1'b0;

    localparam logic [7:0] ON_BASE  = 8'd20;
    localparam logic [6:0] OFF_BIAS = 7'd16;
    localparam logic [7:0] TEST_ON  = 8'd80;
    localparam logic [7:0] TEST_OFF = 8'd20;
    localparam logic [7:0] ALPHA_MAX = 8'hFF;

    // floor(d*0.333) and floor(d*0.667) as d*M >> 20, exact for 8-bit d
    localparam int unsigned W_SHIFT = 20;
    localparam logic [19:0] W0_MULT = 20'd349176;
    localparam logic [19:0] W1_MULT = 20'd699401;

    typedef struct packed {
        logic       accept;
        logic       clr;
        logic       prep;
        logic       rd;
        logic       exec;
        logic       load;
        logic [2:0] dot;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_free;
        t_op  op;
    } t_stat;

    function automatic logic is_result_op(t_op op);
        return (op == OP_BUF_RD) || (op == OP_REG_RD) || (op == OP_FRAME);
    endfunction

endpackage

FILE: rtl/ldmc_plane.sv
module ldmc_plane (
    input  logic                      i_clk,
    input  logic [ldmc_pkg::AW-1:0]   i_addr,
    input  logic                      i_we,
    input  logic [7:0]                i_wdata,
    input  logic                      i_re,
    output logic [7:0]                o_rdata
);

    logic [7:0] r_mem [ldmc_pkg::PLANE_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/ldmc_ctrl.sv
module ldmc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ldmc_pkg::t_stat  i_stat,
    output ldmc_pkg::t_cmd   o_cmd
);

    ldmc_pkg::t_state r_state, n_state;
    logic [2:0]       r_dot, n_dot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ldmc_pkg::S_CLR;
            r_dot   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_dot   <= n_dot;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ldmc_pkg::S_CLR: begin
                if (i_stat.clr_last) n_state = ldmc_pkg::S_IDLE;
            end
            ldmc_pkg::S_IDLE: begin
                if (i_valid) n_state = ldmc_pkg::S_PREP;
            end
            ldmc_pkg::S_PREP: n_state = ldmc_pkg::S_RD;
            ldmc_pkg::S_RD:   n_state = ldmc_pkg::S_EXEC;
            ldmc_pkg::S_EXEC: begin
                if (i_stat.op == ldmc_pkg::OP_SCAN) begin
                    n_state = ldmc_pkg::S_SCAN;
                end else if (!ldmc_pkg::is_result_op(i_stat.op) || i_stat.out_free) begin
                    n_state = ldmc_pkg::S_IDLE;
                end
            end
            ldmc_pkg::S_SCAN: begin
                if (i_stat.out_free && r_dot == 3'd7) n_state = ldmc_pkg::S_IDLE;
            end
            default: n_state = ldmc_pkg::S_CLR;
        endcase
    end

    always_comb begin
        n_dot = r_dot;
        if (r_state == ldmc_pkg::S_SCAN && i_stat.out_free) n_dot = r_dot + 3'd1;
    end

    always_comb begin
        o_ready      = (r_state == ldmc_pkg::S_IDLE);
        o_cmd.accept = (r_state == ldmc_pkg::S_IDLE) && i_valid;
        o_cmd.clr    = (r_state == ldmc_pkg::S_CLR);
        o_cmd.prep   = (r_state == ldmc_pkg::S_PREP);
        o_cmd.rd     = (r_state == ldmc_pkg::S_RD);
        o_cmd.exec   = (r_state == ldmc_pkg::S_EXEC) &&
                       (!ldmc_pkg::is_result_op(i_stat.op) || i_stat.out_free);
        o_cmd.load   = (r_state == ldmc_pkg::S_SCAN) && i_stat.out_free;
        o_cmd.dot    = r_dot;
    end

`ifndef SYNTHESIS
    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == ldmc_pkg::S_PREP))
        else $error("accepted word did not start preparation");

    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ldmc_pkg::S_SCAN && o_cmd.load && r_dot == 3'd7)
        |=> (r_state == ldmc_pkg::S_IDLE))
        else $error("scan did not end after eighth dot");

    a_clr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ldmc_pkg::S_CLR && !i_stat.clr_last) |=> (r_state == ldmc_pkg::S_CLR))
        else $error("clearing pass left early");
`endif

endmodule

FILE: rtl/ldmc_datapath.sv
module ldmc_datapath #(
    parameter int DISPLAY_ROWS = 63,
    parameter int ROW_BYTES    = 32,
    parameter int SHOWN_BYTES  = 24,
    parameter int ROW_OFFSET   = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ldmc_pkg::t_cmd       i_cmd,
    output ldmc_pkg::t_stat      o_stat,
    input  logic [2:0]           i_op,
    input  logic [10:0]          i_address,
    input  logic                 i_plane,
    input  logic [1:0]           i_reg_index,
    input  logic [7:0]           i_write_data,
    input  logic [5:0]           i_row,
    input  logic [4:0]           i_column,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_read_data,
    output logic                 o_dirty,
    output logic                 o_frame_enabled,
    output logic [7:0]           o_dot_alpha,
    output logic [2:0]           o_dot_index,
    output logic                 o_last,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int unsigned AW  = ldmc_pkg::AW;
    localparam int unsigned OW  = 14;
    localparam int unsigned RSH = 20;
    localparam int unsigned PW  = AW + RSH + 1;
    localparam int unsigned RECIP = ((1 << RSH) + ROW_BYTES - 1) / ROW_BYTES;
    localparam logic [OW-1:0] RB_O    = OW'(ROW_BYTES);
    localparam logic [OW-1:0] ROFF_O  = OW'(ROW_OFFSET);
    localparam logic [OW-1:0] PSIZE_O = OW'((DISPLAY_ROWS + 1) * ROW_BYTES);
    localparam logic [OW-1:0] DEPTH_O = OW'(ldmc_pkg::PLANE_DEPTH);
    localparam logic [AW-1:0] RB_A    = AW'(ROW_BYTES);
    localparam logic [AW-1:0] SB_A    = AW'(SHOWN_BYTES);
    localparam logic [6:0]    ROWS_R  = 7'(DISPLAY_ROWS);
    localparam logic [6:0]    SB_C    = 7'(SHOWN_BYTES);

    // item registers
    ldmc_pkg::t_op  r_op;
    ldmc_pkg::t_reg r_ri;
    logic [AW-1:0]  r_addr;
    logic           r_plane;
    logic [7:0]     r_wd;
    logic [5:0]     r_row;
    logic [4:0]     r_col;

    // state registers
    logic [2:0]     r_range, r_mode;
    logic [5:0]     r_contrast;
    logic           r_select, r_dirty;
    logic [1:0]     r_plane_mode;
    logic [AW-1:0]  r_clr_cnt;
    logic           r_out_valid;

    // working registers
    logic [AW-1:0]  r_quot, r_maddr;
    logic           r_scan_ok, r_vis;
    logic [7:0]     r_on, r_off, r_d, r_w0, r_w1, r_b0, r_b1;

    logic [7:0]     r_o_read_data, r_o_dot_alpha;
    logic           r_o_dirty, r_o_frame_enabled, r_o_last;
    logic [2:0]     r_o_dot_index;

    logic [PW-1:0]  s_qprod;
    logic [OW-1:0]  s_so;
    logic           s_so_ok;
    logic [10:0]    s_on_raw;
    logic [6:0]     s_c2;
    logic [7:0]     s_on, s_off, s_d;
    logic [AW-1:0]  s_qrb, s_rem;
    logic [27:0]    s_w0p, s_w1p;
    logic [7:0]     s_rd0, s_rd1, s_bus_rd, s_reg_rd, s_alpha;
    logic           s_sel1, s_disp_on, s_bit0, s_bit1, s_bus_wr;
    logic [8:0]     s_sum;
    logic           s_out_free, s_load_out, s_cfg_wr;
    logic [AW-1:0]  s_maddr;
    logic           s_we0, s_we1;
    logic [7:0]     s_wdata;

    // preparation: offsets, row division, alpha levels
    assign s_qprod  = PW'(r_addr) * PW'(RECIP);
    assign s_so     = OW'(r_row) * RB_O + ROFF_O + OW'(r_col);
    assign s_so_ok  = ({1'b0, r_row} < ROWS_R) && ({2'b00, r_col} < SB_C) &&
                      (s_so < DEPTH_O) && (s_so < PSIZE_O);
    assign s_on_raw = {3'b000, ldmc_pkg::ON_BASE} + {1'b0, r_contrast, 4'b0000};
    assign s_c2     = {r_contrast, 1'b0};

    always_comb begin
        s_on  = (s_on_raw > 11'd255) ? ldmc_pkg::ALPHA_MAX : s_on_raw[7:0];
        s_off = (s_c2 > ldmc_pkg::OFF_BIAS) ? {1'b0, s_c2 - ldmc_pkg::OFF_BIAS} : 8'd0;
        if (r_mode == ldmc_pkg::MODE_TEST) begin
            s_on  = ldmc_pkg::TEST_ON;
            s_off = ldmc_pkg::TEST_OFF;
        end
        s_d = (s_on > s_off) ? s_on - s_off : 8'd0;
    end

    // read stage: hidden column test, plane weights
    assign s_qrb = r_quot * RB_A;
    assign s_rem = r_addr - s_qrb;
    assign s_w0p = 28'(r_d) * 28'(ldmc_pkg::W0_MULT);
    assign s_w1p = 28'(r_d) * 28'(ldmc_pkg::W1_MULT);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= ldmc_pkg::t_op'(i_op);
            r_ri    <= ldmc_pkg::t_reg'(i_reg_index);
            r_addr  <= i_address;
            r_plane <= i_plane;
            r_wd    <= i_write_data;
            r_row   <= i_row;
            r_col   <= i_column;
        end
        if (i_cmd.prep) begin
            r_quot    <= s_qprod[RSH +: AW];
            r_maddr   <= (r_op == ldmc_pkg::OP_SCAN) ? s_so[AW-1:0] : r_addr;
            r_scan_ok <= s_so_ok;
            r_on      <= s_on;
            r_off     <= s_off;
            r_d       <= s_d;
        end
        if (i_cmd.rd) begin
            r_vis <= (s_rem < SB_A) && ({3'b000, r_addr} < PSIZE_O);
            r_w0  <= s_w0p[ldmc_pkg::W_SHIFT +: 8];
            r_w1  <= s_w1p[ldmc_pkg::W_SHIFT +: 8];
        end
        if (i_cmd.exec && r_op == ldmc_pkg::OP_SCAN) begin
            r_b0 <= r_scan_ok ? s_rd0 : 8'd0;
            r_b1 <= r_scan_ok ? s_rd1 : 8'd0;
        end
    end

    // planes
    assign s_sel1   = (r_plane_mode == ldmc_pkg::PM_SINGLE) ? 1'b0 :
                      (r_plane_mode == ldmc_pkg::PM_SPLIT)  ? r_plane : r_select;
    assign s_bus_wr = i_cmd.exec && (r_op == ldmc_pkg::OP_BUF_WR) && r_vis;
    assign s_maddr  = i_cmd.clr ? r_clr_cnt : r_maddr;
    assign s_wdata  = i_cmd.clr ? 8'd0 : r_wd;
    assign s_we0    = i_cmd.clr || (s_bus_wr && !s_sel1);
    assign s_we1    = i_cmd.clr || (s_bus_wr && s_sel1);

    ldmc_plane u_plane0 (
        .i_clk   (i_clk),
        .i_addr  (s_maddr),
        .i_we    (s_we0),
        .i_wdata (s_wdata),
        .i_re    (i_cmd.rd),
        .o_rdata (s_rd0)
    );

    ldmc_plane u_plane1 (
        .i_clk   (i_clk),
        .i_addr  (s_maddr),
        .i_we    (s_we1),
        .i_wdata (s_wdata),
        .i_re    (i_cmd.rd),
        .o_rdata (s_rd1)
    );

    assign s_bus_rd  = r_vis ? (s_sel1 ? s_rd1 : s_rd0) : 8'd0;
    assign s_disp_on = (r_mode == ldmc_pkg::MODE_CLEAR) || (r_mode == ldmc_pkg::MODE_SHOW) ||
                       (r_mode == ldmc_pkg::MODE_TEST);

    always_comb begin
        case (r_ri)
            ldmc_pkg::REG_RANGE:    s_reg_rd = {5'b00000, r_range};
            ldmc_pkg::REG_MODE:     s_reg_rd = {5'b00000, r_mode};
            ldmc_pkg::REG_CONTRAST: s_reg_rd = {2'b00, r_contrast};
            ldmc_pkg::REG_SELECT:   s_reg_rd = (r_plane_mode == ldmc_pkg::PM_SINGLE) ? 8'd0 :
                                               {5'b00000, r_select, 2'b00};
            default:                s_reg_rd = 8'd0;
        endcase
    end

    // dot alpha, MSB first
    assign s_bit0 = r_b0[3'd7 - i_cmd.dot];
    assign s_bit1 = r_b1[3'd7 - i_cmd.dot];
    assign s_sum  = {1'b0, r_off} + (s_bit0 ? {1'b0, r_w0} : 9'd0) +
                    (s_bit1 ? {1'b0, r_w1} : 9'd0);

    always_comb begin
        if (!s_disp_on) begin
            s_alpha = 8'd0;
        end else if (r_mode != ldmc_pkg::MODE_SHOW) begin
            s_alpha = r_off;
        end else if (r_plane_mode == ldmc_pkg::PM_SINGLE) begin
            s_alpha = s_bit0 ? r_on : r_off;
        end else begin
            s_alpha = s_sum[8] ? ldmc_pkg::ALPHA_MAX : s_sum[7:0];
        end
    end

    // output word register
    assign s_out_free = !r_out_valid || i_ready;
    assign s_load_out = i_cmd.load || (i_cmd.exec && ldmc_pkg::is_result_op(r_op));

    always_ff @(posedge i_clk) begin
        if (s_load_out) begin
            r_o_frame_enabled <= s_disp_on;
            r_o_read_data     <= 8'd0;
            r_o_dirty         <= 1'b0;
            r_o_dot_alpha     <= 8'd0;
            r_o_dot_index     <= 3'd0;
            r_o_last          <= 1'b1;
            if (i_cmd.load) begin
                r_o_dot_alpha <= s_alpha;
                r_o_dot_index <= i_cmd.dot;
                r_o_last      <= (i_cmd.dot == 3'd7);
            end else if (r_op == ldmc_pkg::OP_BUF_RD) begin
                r_o_read_data <= s_bus_rd;
            end else if (r_op == ldmc_pkg::OP_REG_RD) begin
                r_o_read_data <= s_reg_rd;
            end else begin
                r_o_dirty <= r_dirty;
            end
        end
    end

    assign s_cfg_wr = psel && penable && pwrite && (paddr[2] == ldmc_pkg::CFG_PLANE_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range      <= 3'd0;
            r_mode       <= 3'd0;
            r_contrast   <= 6'd0;
            r_select     <= 1'b0;
            r_dirty      <= 1'b1;
            r_plane_mode <= ldmc_pkg::PM_SINGLE;
            r_clr_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (s_cfg_wr) r_plane_mode <= pwdata[1:0];
            if (i_cmd.clr) r_clr_cnt <= r_clr_cnt + AW'(1);
            if (s_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.exec) begin
                case (r_op)
                    ldmc_pkg::OP_BUF_WR: begin
                        if (r_vis && s_bus_rd != r_wd) r_dirty <= 1'b1;
                    end
                    ldmc_pkg::OP_REG_WR: begin
                        case (r_ri)
                            ldmc_pkg::REG_RANGE: begin
                                r_range <= r_wd[2:0];
                                r_dirty <= 1'b1;
                            end
                            ldmc_pkg::REG_MODE: begin
                                r_mode  <= r_wd[2:0];
                                r_dirty <= 1'b1;
                            end
                            ldmc_pkg::REG_CONTRAST: begin
                                r_contrast <= r_wd[5:0];
                                r_dirty    <= 1'b1;
                            end
                            ldmc_pkg::REG_SELECT: begin
                                if (r_plane_mode != ldmc_pkg::PM_SINGLE) begin
                                    r_select <= r_wd[2];
                                    r_dirty  <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                    ldmc_pkg::OP_FRAME: r_dirty <= 1'b0;
                    default: ;
                endcase
            end
        end
    end

    assign prdata = (paddr[2] == ldmc_pkg::CFG_PLANE_MODE) ? {30'd0, r_plane_mode} : 32'd0;
    assign pready = 1'b1;

    assign o_stat.clr_last = &r_clr_cnt;
    assign o_stat.out_free = s_out_free;
    assign o_stat.op       = r_op;

    assign o_valid         = r_out_valid;
    assign o_read_data     = r_o_read_data;
    assign o_dirty         = r_o_dirty;
    assign o_frame_enabled = r_o_frame_enabled;
    assign o_dot_alpha     = r_o_dot_alpha;
    assign o_dot_index     = r_o_dot_index;
    assign o_last          = r_o_last;

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_load_out |-> s_out_free)
        else $error("output word overwritten before it was taken");

    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_op == ldmc_pkg::OP_FRAME) |=> !r_dirty)
        else $error("frame start left the dirty flag set");

    a_clr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr |-> !(i_cmd.exec || i_cmd.load || i_cmd.accept))
        else $error("item activity during clearing pass");
`endif

endmodule

FILE: rtl/lcd_dot_matrix_controller.sv
// Dot-matrix LCD controller of a calculator.
// Input channel (i_valid/o_ready) carries one bus word: buffer read or write,
// register read or write, frame start or byte scan. Output channel
// (o_valid/i_ready) returns one word for a read or frame start, eight dot
// words for a scan (dot_index 0 is the MSB, last on the eighth) and none for
// a write. plane_mode sits at APB byte address 0; pready is always high.
// Every word passes accept, prepare, plane read and execute stages: its
// result enters the output register from the execute stage and the next
// word is accepted only after the last has left execute or scan; a scan
// then spends one cycle per dot while the output register is free.
// The controller holds one word at a time, set by the single-port plane RAMs
// and the read-before-write needed for dirty marking.
// After reset both planes are cleared by a pass over every plane address, one
// byte a cycle, with o_ready low; APB writes are taken throughout.
// The output register holds a result until taken. A new word is accepted
// while it waits, but a result that finds it still full waits in the
// execute or scan stage until the receiver takes the pending word.
module lcd_dot_matrix_controller #(
    parameter int DISPLAY_ROWS = 63,
    parameter int ROW_BYTES    = 32,
    parameter int SHOWN_BYTES  = 24,
    parameter int ROW_OFFSET   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_op,
    input  logic [10:0] i_address,
    input  logic        i_plane,
    input  logic [1:0]  i_reg_index,
    input  logic [7:0]  i_write_data,
    input  logic [5:0]  i_row,
    input  logic [4:0]  i_column,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_read_data,
    output logic        o_dirty,
    output logic        o_frame_enabled,
    output logic [7:0]  o_dot_alpha,
    output logic [2:0]  o_dot_index,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ldmc_pkg::t_cmd  s_cmd;
    ldmc_pkg::t_stat s_stat;

    ldmc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (s_stat),
        .o_cmd   (s_cmd)
    );

    ldmc_datapath #(
        .DISPLAY_ROWS (DISPLAY_ROWS),
        .ROW_BYTES    (ROW_BYTES),
        .SHOWN_BYTES  (SHOWN_BYTES),
        .ROW_OFFSET   (ROW_OFFSET)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (s_cmd),
        .o_stat          (s_stat),
        .i_op            (i_op),
        .i_address       (i_address),
        .i_plane         (i_plane),
        .i_reg_index     (i_reg_index),
        .i_write_data    (i_write_data),
        .i_row           (i_row),
        .i_column        (i_column),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_read_data     (o_read_data),
        .o_dirty         (o_dirty),
        .o_frame_enabled (o_frame_enabled),
        .o_dot_alpha     (o_dot_alpha),
        .o_dot_index     (o_dot_index),
        .o_last          (o_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

endmodule

FILE: tb/sv/lcd_dot_matrix_controller_tb.sv
module lcd_dot_matrix_controller_tb;

    localparam int DISPLAY_ROWS = 63;
    localparam int ROW_BYTES    = 32;
    localparam int SHOWN_BYTES  = 24;
    localparam int ROW_OFFSET   = 32;

    localparam logic [2:0] OP_SPARE_A      = 3'd6;
    localparam logic [2:0] OP_SPARE_B      = 3'd7;
    localparam logic [1:0] PM_BY_SELECT    = 2'd2;
    localparam logic [1:0] PM_SELECT_ALIAS = 2'd3;
    localparam logic [2:0] PLANE_MODE_ADDR = {ldmc_pkg::CFG_PLANE_MODE, 2'b00};
    localparam logic [2:0] MODE_OFF        = 3'd0;

    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 10000;

    typedef struct packed {
        logic [2:0]  op;
        logic [10:0] address;
        logic        plane;
        logic [1:0]  reg_index;
        logic [7:0]  write_data;
        logic [5:0]  row;
        logic [4:0]  column;
    } t_bus_word;

    typedef struct packed {
        logic [7:0] read_data;
        logic       dirty;
        logic       frame_enabled;
        logic [7:0] dot_alpha;
        logic [2:0] dot_index;
        logic       last;
    } t_lcd_out;

    class t_lcd_shadow;
        logic [7:0] plane0 [ldmc_pkg::PLANE_DEPTH];
        logic [7:0] plane1 [ldmc_pkg::PLANE_DEPTH];
        logic [2:0] range_q;
        logic [2:0] mode_q;
        logic [5:0] contrast_q;
        logic       select_q;
        logic       redraw_q;
        logic [1:0] plane_mode;
        t_lcd_out   due[$];
        int         words;
        int         scans;
        int         writes;
        int         checked;
        int         errors;

        function new();
            foreach (plane0[i]) begin
                plane0[i] = 8'd0;
                plane1[i] = 8'd0;
            end
            range_q    = 3'd0;
            mode_q     = 3'd0;
            contrast_q = 6'd0;
            select_q   = 1'b0;
            redraw_q   = 1'b1;
            plane_mode = ldmc_pkg::PM_SINGLE;
        endfunction

        function bit display_on();
            return mode_q == ldmc_pkg::MODE_CLEAR || mode_q == ldmc_pkg::MODE_SHOW ||
                   mode_q == ldmc_pkg::MODE_TEST;
        endfunction

        function bit visible(logic [10:0] a);
            return int'(a) < (DISPLAY_ROWS + 1) * ROW_BYTES &&
                   int'(a) % ROW_BYTES < SHOWN_BYTES;
        endfunction

        function void push(logic [7:0] rd, logic drt, logic [7:0] alpha,
                           logic [2:0] idx, logic fin);
            t_lcd_out r;
            r.read_data     = rd;
            r.dirty         = drt;
            r.frame_enabled = display_on();
            r.dot_alpha     = alpha;
            r.dot_index     = idx;
            r.last          = fin;
            due.push_back(r);
        endfunction

        function void note_word(t_bus_word w);
            logic       use_one;
            logic [7:0] cur;
            logic [7:0] rd;
            logic [7:0] b0;
            logic [7:0] b1;
            logic [7:0] m;
            int         c;
            int         on;
            int         off;
            int         d;
            int         w0;
            int         w1;
            int         a;
            int         o;
            words++;
            if (plane_mode == ldmc_pkg::PM_SINGLE)
                use_one = 1'b0;
            else if (plane_mode == ldmc_pkg::PM_SPLIT)
                use_one = w.plane;
            else
                use_one = select_q;
            case (w.op)
                ldmc_pkg::OP_BUF_RD: begin
                    rd = 8'd0;
                    if (visible(w.address))
                        rd = use_one ? plane1[w.address] : plane0[w.address];
                    push(rd, 1'b0, 8'd0, 3'd0, 1'b1);
                end
                ldmc_pkg::OP_BUF_WR: begin
                    writes++;
                    if (visible(w.address)) begin
                        cur = use_one ? plane1[w.address] : plane0[w.address];
                        if (cur != w.write_data)
                            redraw_q = 1'b1;
                        if (use_one)
                            plane1[w.address] = w.write_data;
                        else
                            plane0[w.address] = w.write_data;
                    end
                end
                ldmc_pkg::OP_REG_RD: begin
                    case (w.reg_index)
                        ldmc_pkg::REG_RANGE:    rd = {5'd0, range_q};
                        ldmc_pkg::REG_MODE:     rd = {5'd0, mode_q};
                        ldmc_pkg::REG_CONTRAST: rd = {2'd0, contrast_q};
                        default: rd = (plane_mode == ldmc_pkg::PM_SINGLE) ? 8'd0
                                                                          : {5'd0, select_q, 2'd0};
                    endcase
                    push(rd, 1'b0, 8'd0, 3'd0, 1'b1);
                end
                ldmc_pkg::OP_REG_WR: begin
                    case (w.reg_index)
                        ldmc_pkg::REG_RANGE: begin
                            range_q  = w.write_data[2:0];
                            redraw_q = 1'b1;
                        end
                        ldmc_pkg::REG_MODE: begin
                            mode_q   = w.write_data[2:0];
                            redraw_q = 1'b1;
                        end
                        ldmc_pkg::REG_CONTRAST: begin
                            contrast_q = w.write_data[5:0];
                            redraw_q   = 1'b1;
                        end
                        default: begin
                            if (plane_mode != ldmc_pkg::PM_SINGLE) begin
                                select_q = w.write_data[2];
                                redraw_q = 1'b1;
                            end
                        end
                    endcase
                end
                ldmc_pkg::OP_FRAME: begin
                    push(8'd0, redraw_q, 8'd0, 3'd0, 1'b1);
                    redraw_q = 1'b0;
                end
                ldmc_pkg::OP_SCAN: begin
                    scans++;
                    c   = contrast_q;
                    on  = ldmc_pkg::ON_BASE + 16 * c;
                    off = (2 * c > ldmc_pkg::OFF_BIAS) ? 2 * c - ldmc_pkg::OFF_BIAS : 0;
                    if (on > ldmc_pkg::ALPHA_MAX)
                        on = ldmc_pkg::ALPHA_MAX;
                    if (mode_q == ldmc_pkg::MODE_TEST) begin
                        on  = ldmc_pkg::TEST_ON;
                        off = ldmc_pkg::TEST_OFF;
                    end
                    b0 = 8'd0;
                    b1 = 8'd0;
                    if (w.row < DISPLAY_ROWS && w.column < SHOWN_BYTES) begin
                        o = w.row * ROW_BYTES + ROW_OFFSET + w.column;
                        if (o < ldmc_pkg::PLANE_DEPTH &&
                            o < (DISPLAY_ROWS + 1) * ROW_BYTES) begin
                            b0 = plane0[o];
                            b1 = plane1[o];
                        end
                    end
                    d  = (on > off) ? on - off : 0;
                    w0 = d * 333 / 1000;
                    w1 = d * 667 / 1000;
                    for (int k = 0; k < 8; k++) begin
                        m = 8'h80 >> k;
                        a = 0;
                        if (display_on()) begin
                            if (mode_q != ldmc_pkg::MODE_SHOW)
                                a = off;
                            else if (plane_mode == ldmc_pkg::PM_SINGLE)
                                a = ((b0 & m) != 0) ? on : off;
                            else
                                a = off + (((b0 & m) != 0) ? w0 : 0)
                                        + (((b1 & m) != 0) ? w1 : 0);
                        end
                        if (a > ldmc_pkg::ALPHA_MAX)
                            a = ldmc_pkg::ALPHA_MAX;
                        push(8'd0, 1'b0, 8'(a), 3'(k), k == 7);
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
            if (got_v !== exp_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_word(t_lcd_out got);
            t_lcd_out exp_w;
            if (due.size() == 0) begin
                $error("result word with nothing outstanding");
                errors++;
                return;
            end
            exp_w = due.pop_front();
            checked++;
            compare_field("read_data", exp_w.read_data, got.read_data);
            compare_field("dirty", 8'(exp_w.dirty), 8'(got.dirty));
            compare_field("frame_enabled", 8'(exp_w.frame_enabled), 8'(got.frame_enabled));
            compare_field("dot_alpha", exp_w.dot_alpha, got.dot_alpha);
            compare_field("dot_index", 8'(exp_w.dot_index), 8'(got.dot_index));
            compare_field("last", 8'(exp_w.last), 8'(got.last));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_op;
    logic [10:0] i_address;
    logic        i_plane;
    logic [1:0]  i_reg_index;
    logic [7:0]  i_write_data;
    logic [5:0]  i_row;
    logic [4:0]  i_column;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_read_data;
    logic        o_dirty;
    logic        o_frame_enabled;
    logic [7:0]  o_dot_alpha;
    logic [2:0]  o_dot_index;
    logic        o_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    t_lcd_shadow sb;
    t_lcd_out    seen;
    int          ready_hold;
    int          quiet;
    bit          calm;

    lcd_dot_matrix_controller i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_address       (i_address),
        .i_plane         (i_plane),
        .i_reg_index     (i_reg_index),
        .i_write_data    (i_write_data),
        .i_row           (i_row),
        .i_column        (i_column),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_read_data     (o_read_data),
        .o_dirty         (o_dirty),
        .o_frame_enabled (o_frame_enabled),
        .o_dot_alpha     (o_dot_alpha),
        .o_dot_index     (o_dot_index),
        .o_last          (o_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    // receiver stalls, drawn afresh after every word taken
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            i_ready = 1'b0;
            ready_hold--;
        end else begin
            i_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet = 0;
            else
                quiet++;
            if (o_valid && i_ready) begin
                seen.read_data     = o_read_data;
                seen.dirty         = o_dirty;
                seen.frame_enabled = o_frame_enabled;
                seen.dot_alpha     = o_dot_alpha;
                seen.dot_index     = o_dot_index;
                seen.last          = o_last;
                sb.check_word(seen);
                ready_hold = draw_gap();
            end
            if (quiet >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic t_bus_word mk(logic [2:0] op, logic [10:0] addr, logic pl,
                                     logic [1:0] ri, logic [7:0] wd,
                                     logic [5:0] row, logic [4:0] col);
        t_bus_word w;
        w.op         = op;
        w.address    = addr;
        w.plane      = pl;
        w.reg_index  = ri;
        w.write_data = wd;
        w.row        = row;
        w.column     = col;
        return w;
    endfunction

    // scan rows whose bytes the random writes keep busy
    function automatic logic [5:0] hot_row();
        case ($urandom_range(0, 4))
            0:       return 6'd0;
            1:       return 6'd1;
            2:       return 6'd2;
            3:       return 6'd61;
            default: return 6'd62;
        endcase
    endfunction

    function automatic logic [4:0] hot_col();
        return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 23))
                                           : 5'($urandom_range(0, 5));
    endfunction

    function automatic t_bus_word random_word();
        t_bus_word w;
        int        pick;
        w = mk(3'd0, 11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)),
               2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
               6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)));
        pick = $urandom_range(0, 99);
        if (pick < 2)       w.op = OP_SPARE_A;
        else if (pick < 3)  w.op = OP_SPARE_B;
        else if (pick < 33) w.op = ldmc_pkg::OP_BUF_WR;
        else if (pick < 48) w.op = ldmc_pkg::OP_BUF_RD;
        else if (pick < 73) w.op = ldmc_pkg::OP_SCAN;
        else if (pick < 85) w.op = ldmc_pkg::OP_REG_WR;
        else if (pick < 93) w.op = ldmc_pkg::OP_REG_RD;
        else                w.op = ldmc_pkg::OP_FRAME;
        if ($urandom_range(0, 9) < 7)
            w.address = 11'((hot_row() + 1) * ROW_BYTES + hot_col());
        if ($urandom_range(0, 99) < 85) begin
            w.row    = hot_row();
            w.column = hot_col();
        end
        if (w.op == ldmc_pkg::OP_REG_WR && w.reg_index == ldmc_pkg::REG_MODE) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      w.write_data = {5'($urandom), ldmc_pkg::MODE_SHOW};
            else if (pick < 72) w.write_data = {5'($urandom), ldmc_pkg::MODE_CLEAR};
            else if (pick < 84) w.write_data = {5'($urandom), ldmc_pkg::MODE_TEST};
        end
        return w;
    endfunction

    task automatic send_word(input t_bus_word w);
        int gap;
        if ($urandom_range(0, 23) == 0)
            calm = !calm;
        gap = draw_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_op         = w.op;
        i_address    = w.address;
        i_plane      = w.plane;
        i_reg_index  = w.reg_index;
        i_write_data = w.write_data;
        i_row        = w.row;
        i_column     = w.column;
        i_valid      = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        sb.note_word(w);
    endtask

    task automatic run_random(input int count);
        t_bus_word w;
        int        n;
        n = 0;
        while (n < count) begin
            w = random_word();
            send_word(w);
            if (w.op != OP_SPARE_A && w.op != OP_SPARE_B)
                n++;
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_plane_mode(input logic [1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = PLANE_MODE_ADDR;
        pwdata  = 32'(value);
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.plane_mode = value;
        @(negedge i_clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(value)) begin
            $error("plane_mode readback: expected %0d, got %0d", value, prdata);
            sb.errors++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_mode(input logic [2:0] mode);
        send_word(mk(ldmc_pkg::OP_REG_WR, 11'd0, 1'b0, ldmc_pkg::REG_MODE,
                     {5'd0, mode}, 6'd0, 5'd0));
    endtask

    task automatic run_directed();
        send_word(mk(ldmc_pkg::OP_FRAME, 11'd0, 1'b0, ldmc_pkg::REG_RANGE, 8'd0, 6'd0, 5'd0));
        send_word(mk(ldmc_pkg::OP_FRAME, 11'd0, 1'b0, ldmc_pkg::REG_RANGE, 8'd0, 6'd0, 5'd0));
        send_word(mk(ldmc_pkg::OP_REG_WR, 11'd0, 1'b0, ldmc_pkg::REG_CONTRAST, 8'hFF,
                     6'd0, 5'd0));
        set_mode(ldmc_pkg::MODE_SHOW);
        send_word(mk(ldmc_pkg::OP_REG_WR, 11'd0, 1'b0, ldmc_pkg::REG_RANGE, 8'hFF, 6'd0, 5'd0));
        // select register is absent with a single plane
        send_word(mk(ldmc_pkg::OP_REG_WR, 11'd0, 1'b1, ldmc_pkg::REG_SELECT, 8'hFF,
                     6'd0, 5'd0));
        send_word(mk(ldmc_pkg::OP_REG_RD, 11'd0, 1'b0, ldmc_pkg::REG_RANGE, 8'd0, 6'd0, 5'd0));
        send_word(mk(ldmc_pkg::OP_REG_RD, 11'd0, 1'b0, ldmc_pkg::REG_MODE, 8'd0, 6'd0, 5'd0));
        send_word(mk(ldmc_pkg::OP_REG_RD, 11'd0, 1'b0, ldmc_pkg::REG_CONTRAST, 8'd0,
                     6'd0, 5'd0));
        send_word(mk(ldmc_pkg::OP_REG_RD, 11'd0, 1'b0, ldmc_pkg::REG_SELECT, 8'd0, 6'd0, 5'd0));
        send_word(mk(ldmc_pkg::OP_BUF_WR, 11'd32, 1'b0, ldmc_pkg::REG_RANGE, 8'hA5, 6'd0, 5'd0));
        send_word(mk(ldmc_pkg::OP_FRAME, 11'd0, 1'b0, ldmc_pkg::REG_RANGE, 8'd0, 6'd0, 5'd0));
        // unchanged byte leaves the frame clean
        send_word(mk(ldmc_pkg::OP_BUF_WR, 11'd32, 1'b0, ldmc_pkg::REG_RANGE, 8'hA5, 6'd0, 5'd0));
        send_word(mk(ldmc_pkg::OP_FRAME, 11'd0, 1'b0, ldmc_pkg::REG_RANGE, 8'd0, 6'd0, 5'd0));
        send_word(mk(ldmc_pkg::OP_BUF_WR, 11'd24, 1'b0, ldmc_pkg::REG_RANGE, 8'hFF, 6'd0, 5'd0));
        send_word(mk(ldmc_pkg::OP_BUF_RD, 11'd24, 1'b0, ldmc_pkg::REG_RANGE, 8'd0, 6'd0, 5'd0));
        send_word(mk(ldmc_pkg::OP_BUF_WR, 11'h7FF, 1'b1, ldmc_pkg::REG_SELECT, 8'hFF,
                     6'h3F, 5'h1F));
        send_word(mk(ldmc_pkg::OP_BUF_RD, 11'h7FF, 1'b0, ldmc_pkg::REG_RANGE, 8'd0, 6'd0, 5'd0));
        send_word(mk(ldmc_pkg::OP_SCAN, 11'd0, 1'b0, ldmc_pkg::REG_RANGE, 8'd0, 6'd0, 5'd0));
        send_word(mk(ldmc_pkg::OP_SCAN, 11'd0, 1'b0, ldmc_pkg::REG_RANGE, 8'd0, 6'd63, 5'd31));
        send_word(mk(OP_SPARE_A, 11'd0, 1'b0, ldmc_pkg::REG_RANGE, 8'd0, 6'd0, 5'd0));
        send_word(mk(OP_SPARE_B, 11'd0, 1'b0, ldmc_pkg::REG_RANGE, 8'd0, 6'd0, 5'd0));
        set_mode(ldmc_pkg::MODE_CLEAR);
        send_word(mk(ldmc_pkg::OP_SCAN, 11'd0, 1'b0, ldmc_pkg::REG_RANGE, 8'd0, 6'd0, 5'd0));
        set_mode(ldmc_pkg::MODE_TEST);
        send_word(mk(ldmc_pkg::OP_SCAN, 11'd0, 1'b0, ldmc_pkg::REG_RANGE, 8'd0, 6'd0, 5'd0));
        set_mode(MODE_OFF);
        send_word(mk(ldmc_pkg::OP_SCAN, 11'd0, 1'b0, ldmc_pkg::REG_RANGE, 8'd0, 6'd0, 5'd0));
    endtask

    initial begin : stimulus
        logic [1:0] plane_modes [4];
        plane_modes  = '{ldmc_pkg::PM_SPLIT, PM_BY_SELECT, PM_SELECT_ALIAS,
                         ldmc_pkg::PM_SINGLE};
        sb           = new();
        ready_hold   = 0;
        quiet        = 0;
        calm         = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_ready      = 1'b0;
        i_op         = 3'd0;
        i_address    = 11'd0;
        i_plane      = 1'b0;
        i_reg_index  = 2'd0;
        i_write_data = 8'd0;
        i_row        = 6'd0;
        i_column     = 5'd0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = 3'd0;
        pwdata       = 32'd0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_plane_mode(ldmc_pkg::PM_SINGLE);
        run_directed();
        run_random(20);
        foreach (plane_modes[i]) begin
            settle();
            write_plane_mode(plane_modes[i]);
            run_random(66);
        end
        settle();

        $display("%0d bus words sent (%0d scans, %0d buffer writes), %0d result words checked",
                 sb.words, sb.scans, sb.writes, sb.checked);
        $display("plane modes 0 to 3 visited, display modes off, clear, show and test");
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ldmc_pkg.sv
rtl/ldmc_plane.sv
rtl/ldmc_ctrl.sv
rtl/ldmc_datapath.sv
rtl/lcd_dot_matrix_controller.sv
tb/sv/lcd_dot_matrix_controller_tb.sv
